FILE: src/klx_pkg.sv
// ============================================================================
// klx_pkg
// Shared types, token codes and keyword table for the keyword lexer.
// ============================================================================
package klx_pkg;

    localparam int MAX_LEXEME_DEF    = 99;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int KW_COUNT          = 10;
    localparam int KW_MAX_LEN        = 8;
    localparam int RES_FIFO_DEPTH    = 4;

    localparam logic [5:0] TK_INTEIRO  = 6'd0;
    localparam logic [5:0] TK_PLUS     = 6'd10;
    localparam logic [5:0] TK_MINUS    = 6'd11;
    localparam logic [5:0] TK_MUL      = 6'd12;
    localparam logic [5:0] TK_DIV      = 6'd13;
    localparam logic [5:0] TK_AND      = 6'd14;
    localparam logic [5:0] TK_OR       = 6'd15;
    localparam logic [5:0] TK_LT       = 6'd16;
    localparam logic [5:0] TK_LE       = 6'd17;
    localparam logic [5:0] TK_GT       = 6'd18;
    localparam logic [5:0] TK_GE       = 6'd19;
    localparam logic [5:0] TK_EQEQ     = 6'd20;
    localparam logic [5:0] TK_ASSIGN   = 6'd21;
    localparam logic [5:0] TK_SEMI     = 6'd22;
    localparam logic [5:0] TK_COMMA    = 6'd23;
    localparam logic [5:0] TK_LPAREN   = 6'd24;
    localparam logic [5:0] TK_RPAREN   = 6'd25;
    localparam logic [5:0] TK_LBRACE   = 6'd26;
    localparam logic [5:0] TK_RBRACE   = 6'd27;
    localparam logic [5:0] TK_IDENT    = 6'd28;
    localparam logic [5:0] TK_NUM_INT  = 6'd29;
    localparam logic [5:0] TK_NUM_REAL = 6'd30;
    localparam logic [5:0] TK_EOF      = 6'd31;
    localparam logic [5:0] TK_ERROR    = 6'd32;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {8'h00, "oriet", "ni"} ,
        {32'h0, "laer"},
        {48'h0, "es"},
        {24'h0, "oatne"},
        {24'h0, "oanes"},
        {"otnauqne"},
        {16'h0, "atiper"},
        {40'h0, "eta"},
        {40'h0, "rel"},
        {8'h00, "rartsom"}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd4, 4'd2, 4'd5, 4'd5, 4'd8, 4'd6, 4'd3, 4'd3, 4'd7
    };

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_IDENT   = 12'b0000_0000_0010,
        S_NUM     = 12'b0000_0000_0100,
        S_NUM_DOT = 12'b0000_0000_1000,
        S_SLASH   = 12'b0000_0001_0000,
        S_COMMENT = 12'b0000_0010_0000,
        S_CSTAR   = 12'b0000_0100_0000,
        S_LT      = 12'b0000_1000_0000,
        S_GT      = 12'b0001_0000_0000,
        S_EQ      = 12'b0010_0000_0000,
        S_AMP     = 12'b0100_0000_0000,
        S_BAR     = 12'b1000_0000_0000
    } scan_state_t;

    typedef struct packed {
        logic [7:0] bad_char;
        logic [6:0] lexeme_length;
        logic [5:0] token_code;
    } token_t;

    typedef struct packed {
        logic   last;
        token_t tok;
    } res_entry_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic token_t make_tok(input logic [5:0] code, input logic [6:0] len,
                                        input logic [7:0] bad);
        token_t t;
        t.token_code    = code;
        t.lexeme_length = len;
        t.bad_char      = bad;
        return t;
    endfunction

endpackage

FILE: src/keyword_lexer_byte_stream.sv
// ============================================================================
// keyword_lexer_byte_stream
// Byte-stream lexer: turns source bytes into token words with code, length
// and the offending byte on error.
// ============================================================================
//  Channel | Direction | Content
//  s_*     | in        | tdata: in_byte [7:0]; tuser: mode [0]
//  m_*     | out       | tdata: token_code [5:0], lexeme_length [12:6],
//          |           |        bad_char [20:13], zero [23:21]; tlast: last
//
//  The input register feeds the result queue directly, so one word per cycle
//  is taken while the four-entry result queue has room for two results. A
//  byte that yields two tokens writes both into the queue at once.
//  Reset clears the scan state, the halt flag and the queue.
//  A stall on the output fills the queue and then holds the input register.
// ============================================================================
module keyword_lexer_byte_stream
#(
    parameter int MAX_LEXEME    = klx_pkg::MAX_LEXEME_DEF,
    parameter int KEYWORD_CHARS = klx_pkg::KEYWORD_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte [7:0]
    input  logic        s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // token_code, lexeme_length, bad_char, zero pad
    output logic        m_tlast
);
    import klx_pkg::*;

    localparam int CW = $clog2(MAX_LEXEME + 1);
    localparam int PW = $clog2(RES_FIFO_DEPTH);
    localparam int QW = $clog2(RES_FIFO_DEPTH + 1);

    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [7:0]        in_byte_reg;
    scan_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              real_reg, real_next;
    logic              halted_reg, halted_next;
    logic [7:0]        chars_reg [KEYWORD_CHARS];
    logic              char_we;
    logic [CW-1:0]     char_idx;
    res_entry_t        fifo_reg [RES_FIFO_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QW-1:0]     fill_reg;
    logic              process, pop;
    logic              first_v, second_v;
    token_t            first_tok, second_tok;
    logic [1:0]        nres;
    token_t            out0, out1;
    logic [7:0]        b;
    logic              flush_v, flush_fail;
    token_t            flush_tok;
    logic              fresh_v, fresh_fail, fresh_start;
    token_t            fresh_tok;
    scan_state_t       fresh_state;
    logic [5:0]        ident_code;
    logic              kw_hit;
    logic              overflow;
    logic [6:0]        len7;

    assign b        = in_byte_reg;
    assign process  = in_valid_reg && (fill_reg <= QW'(RES_FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || process;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = fill_reg != '0;
    assign m_tdata  = {3'b000, fifo_reg[rd_ptr_reg].tok};
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;
    assign len7     = 7'(count_reg);
    assign overflow = count_reg >= CW'(MAX_LEXEME);

    always_comb
    begin
        ident_code = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            kw_hit = count_reg == CW'(KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < int'(KW_LEN[k]) && chars_reg[i] != KW_TEXT[k][i])
                begin
                    kw_hit = 1'b0;
                end
            end
            if (kw_hit)
            begin
                ident_code = 6'(k);
            end
        end
    end

    always_comb
    begin
        flush_v    = 1'b1;
        flush_fail = 1'b0;
        flush_tok  = make_tok(TK_ERROR, 7'd1, 8'h00);
        case (state_reg)
            S_IDENT:   flush_tok = make_tok(ident_code, len7, 8'h00);
            S_NUM,
            S_NUM_DOT: flush_tok = make_tok(real_reg ? TK_NUM_REAL : TK_NUM_INT, len7, 8'h00);
            S_SLASH:   flush_tok = make_tok(TK_DIV, 7'd1, 8'h00);
            S_LT:      flush_tok = make_tok(TK_LT, 7'd1, 8'h00);
            S_GT:      flush_tok = make_tok(TK_GT, 7'd1, 8'h00);
            S_EQ:      flush_tok = make_tok(TK_ASSIGN, 7'd1, 8'h00);
            S_AMP:
            begin
                flush_fail = 1'b1;
                flush_tok  = make_tok(TK_ERROR, 7'd1, CH_AMP);
            end
            S_BAR:
            begin
                flush_fail = 1'b1;
                flush_tok  = make_tok(TK_ERROR, 7'd1, CH_BAR);
            end
            default:   flush_v = 1'b0;
        endcase
    end

    always_comb
    begin
        fresh_v     = 1'b1;
        fresh_fail  = 1'b0;
        fresh_start = 1'b0;
        fresh_state = S_IDLE;
        fresh_tok   = make_tok(TK_ERROR, 7'd1, b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF)
        begin
            fresh_v = 1'b0;
        end
        else if (is_alpha(b) || is_digit(b))
        begin
            fresh_v     = 1'b0;
            fresh_start = 1'b1;
            fresh_state = is_alpha(b) ? S_IDENT : S_NUM;
        end
        else
        begin
            case (b)
                CH_SLASH: begin fresh_v = 1'b0; fresh_state = S_SLASH; end
                CH_LT:    begin fresh_v = 1'b0; fresh_state = S_LT; end
                CH_GT:    begin fresh_v = 1'b0; fresh_state = S_GT; end
                CH_EQ:    begin fresh_v = 1'b0; fresh_state = S_EQ; end
                CH_AMP:   begin fresh_v = 1'b0; fresh_state = S_AMP; end
                CH_BAR:   begin fresh_v = 1'b0; fresh_state = S_BAR; end
                CH_PLUS:  fresh_tok = make_tok(TK_PLUS, 7'd1, 8'h00);
                CH_MINUS: fresh_tok = make_tok(TK_MINUS, 7'd1, 8'h00);
                CH_STAR:  fresh_tok = make_tok(TK_MUL, 7'd1, 8'h00);
                CH_SEMI:  fresh_tok = make_tok(TK_SEMI, 7'd1, 8'h00);
                CH_COMMA: fresh_tok = make_tok(TK_COMMA, 7'd1, 8'h00);
                CH_LPAR:  fresh_tok = make_tok(TK_LPAREN, 7'd1, 8'h00);
                CH_RPAR:  fresh_tok = make_tok(TK_RPAREN, 7'd1, 8'h00);
                CH_LBRC:  fresh_tok = make_tok(TK_LBRACE, 7'd1, 8'h00);
                CH_RBRC:  fresh_tok = make_tok(TK_RBRACE, 7'd1, 8'h00);
                default:  fresh_fail = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        logic do_append;
        logic do_fresh;
        logic do_flush_fresh;

        do_append      = 1'b0;
        do_fresh       = 1'b0;
        do_flush_fresh = 1'b0;
        state_next     = state_reg;
        count_next     = count_reg;
        real_next      = real_reg;
        halted_next    = halted_reg;
        char_we        = 1'b0;
        char_idx       = count_reg;
        first_v        = 1'b0;
        second_v       = 1'b0;
        first_tok      = flush_tok;
        second_tok     = fresh_tok;

        if (halted_reg)
        begin
            state_next = state_reg;
        end
        else if (in_mode_reg)
        begin
            first_v    = flush_v;
            state_next = S_IDLE;
            if (flush_fail)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                second_v   = 1'b1;
                second_tok = make_tok(TK_EOF, 7'd0, 8'h00);
            end
        end
        else
        begin
            case (state_reg)
                S_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == CH_UNDER)
                        do_append = 1'b1;
                    else
                        do_flush_fresh = 1'b1;
                end
                S_NUM:
                begin
                    if (is_digit(b))
                    begin
                        do_append = 1'b1;
                    end
                    else if (b == CH_DOT)
                    begin
                        do_append = 1'b1;
                        if (!overflow)
                        begin
                            real_next  = 1'b1;
                            state_next = S_NUM_DOT;
                        end
                    end
                    else
                    begin
                        do_flush_fresh = 1'b1;
                    end
                end
                S_NUM_DOT:
                begin
                    if (is_digit(b))
                    begin
                        do_append = 1'b1;
                        if (!overflow)
                            state_next = S_NUM;
                    end
                    else
                    begin
                        do_flush_fresh = 1'b1;
                    end
                end
                S_SLASH:
                begin
                    if (b == CH_STAR)
                        state_next = S_COMMENT;
                    else
                        do_flush_fresh = 1'b1;
                end
                S_COMMENT:
                begin
                    if (b == CH_STAR)
                        state_next = S_CSTAR;
                end
                S_CSTAR:
                begin
                    if (b == CH_SLASH)
                        state_next = S_IDLE;
                    else if (b != CH_STAR)
                        state_next = S_COMMENT;
                end
                S_LT, S_GT, S_EQ:
                begin
                    if (b == CH_EQ)
                    begin
                        first_v    = 1'b1;
                        first_tok  = make_tok((state_reg == S_LT) ? TK_LE :
                                              (state_reg == S_GT) ? TK_GE : TK_EQEQ,
                                              7'd2, 8'h00);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        do_flush_fresh = 1'b1;
                    end
                end
                S_AMP, S_BAR:
                begin
                    first_v    = 1'b1;
                    state_next = S_IDLE;
                    if ((state_reg == S_AMP && b == CH_AMP) ||
                        (state_reg == S_BAR && b == CH_BAR))
                        first_tok = make_tok((state_reg == S_AMP) ? TK_AND : TK_OR,
                                             7'd2, 8'h00);
                    else
                        halted_next = 1'b1;
                end
                default:
                begin
                    do_fresh = 1'b1;
                end
            endcase

            if (do_append)
            begin
                if (overflow)
                begin
                    first_v     = 1'b1;
                    first_tok   = make_tok(TK_ERROR, 7'(MAX_LEXEME), b);
                    halted_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    char_we    = int'(count_reg) < KEYWORD_CHARS;
                    count_next = count_reg + CW'(1);
                end
            end

            if (do_flush_fresh)
            begin
                first_v  = 1'b1;
                do_fresh = 1'b1;
            end

            if (do_fresh)
            begin
                state_next = fresh_state;
                second_v   = fresh_v || fresh_fail;
                second_tok = fresh_tok;
                if (fresh_fail)
                    halted_next = 1'b1;
                if (fresh_start)
                begin
                    count_next = CW'(1);
                    char_we    = 1'b1;
                    char_idx   = '0;
                    real_next  = 1'b0;
                end
            end
        end

        if (!process)
        begin
            first_v  = 1'b0;
            second_v = 1'b0;
        end
    end

    assign nres = {1'b0, first_v} + {1'b0, second_v};
    assign out0 = first_v ? first_tok : second_tok;
    assign out1 = second_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            real_reg     <= 1'b0;
            halted_reg   <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (process)
            begin
                state_reg  <= state_next;
                count_reg  <= count_next;
                real_reg   <= real_next;
                halted_reg <= halted_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PW'(nres);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            fill_reg <= fill_reg + QW'(nres) - QW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (process && char_we)
        begin
            for (int i = 0; i < KEYWORD_CHARS; i++)
            begin
                if (char_idx == CW'(i))
                    chars_reg[i] <= b;
            end
        end
        if (nres != 2'd0)
        begin
            fifo_reg[wr_ptr_reg].tok  <= out0;
            fifo_reg[wr_ptr_reg].last <= nres == 2'd1;
        end
        if (nres == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PW'(1)].tok  <= out1;
            fifo_reg[wr_ptr_reg + PW'(1)].last <= 1'b1;
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the keyword lexer. A short table of directed source
// bytes comes first, then about 1600 bytes of generated source text: keywords
// and near-keywords, identifiers and numbers up to the length limit, every
// operator and punctuation mark, blanks, comments with arbitrary content, and
// end-of-input markers at random points. A behavioral model of the scanner
// predicts every token word, and the bench compares each word the block
// returns against it, field by field. Because an error halts the block until
// reset, the run ends with one randomly chosen error case followed by a few
// words that must produce nothing. Both stream sides stall at random.
// ============================================================================
module tb_top;
    import klx_pkg::*;

    localparam int          MAX_LEN      = MAX_LEXEME_DEF;
    localparam int          KW_CHARS     = KEYWORD_CHARS_DEF;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [5:0] code;
        logic [6:0] len;
        logic [7:0] bad;
        logic       last;
    } token_word_t;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } src_word_t;

    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
        logic       typed;
        logic [5:0] code;
        logic [6:0] len;
        logic [7:0] bad;
    } probe_row_t;

    typedef enum {PIECE_OTHER, PIECE_WORD, PIECE_NUMBER, PIECE_END} piece_t;
    typedef enum {FAULT_STRAY, FAULT_AMP, FAULT_BAR, FAULT_OPEN_END, FAULT_TOO_LONG} fault_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int unsigned snd_idle      = 38;
    int unsigned rcv_idle      = 81;
    int unsigned words_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;

    token_word_t tokens_due [$];
    src_word_t   script [$];

    string kw_words [10] = '{"inteiro", "real", "se", "entao", "senao", "enquanto",
                             "repita", "ate", "ler", "mostrar"};
    string letters     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string digits      = "0123456789";
    string word_tail   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string blanks      = " \t\n";
    string punct_chars = ";,(){}";
    string op_text [12] = '{"+", "-", "*", "/", "&&", "||", "<", "<=", ">", ">=", "==", "="};

    scan_state_t lx_state = S_IDLE;
    int unsigned lx_count = 0;
    logic [7:0]  lx_head [KW_CHARS] = '{default: 8'h00};
    bit          lx_real  = 1'b0;
    bit          lx_halt  = 1'b0;

    probe_row_t probe_rows [29] = '{
        '{1'b1, 8'hA5,    1'b1, TK_EOF,  7'd0, 8'h00},
        '{1'b0, CH_PLUS,  1'b1, TK_PLUS, 7'd1, 8'h00},
        '{1'b0, "s",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, "e",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_LT,    1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_EQ,    1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, "1",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_DOT,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, "5",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_SEMI,  1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_SLASH, 1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_STAR,  1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_STAR,  1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_STAR,  1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_SLASH, 1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_SLASH, 1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_EQ,    1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_EQ,    1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_AMP,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_AMP,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_BAR,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_BAR,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_GT,    1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, "x",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_UNDER, 1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_SPACE, 1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, "4",      1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b0, CH_DOT,   1'b0, 6'd0, 7'd0, 8'h00},
        '{1'b1, 8'h5A,    1'b0, 6'd0, 7'd0, 8'h00}
    };

    keyword_lexer_byte_stream dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit can_open(logic [7:0] b);
        string openers = " \t\n/<>=&|+-*;,(){}";
        if (is_letter(b) || is_num(b))
            return 1'b1;
        for (int i = 0; i < openers.len(); i++)
            if (openers[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void lx_note(logic [5:0] code, int unsigned len, logic [7:0] bad);
        token_word_t w;
        w.code = code;
        w.len  = 7'(len);
        w.bad  = bad;
        w.last = 1'b0;
        tokens_due.push_back(w);
    endfunction

    function automatic void lx_fail(int unsigned len, logic [7:0] bad);
        lx_note(TK_ERROR, len, bad);
        lx_halt  = 1'b1;
        lx_state = S_IDLE;
    endfunction

    function automatic logic [5:0] lx_word_code();
        bit same;
        for (int k = 0; k < 10; k++)
        begin
            same = (lx_count == kw_words[k].len()) && (kw_words[k].len() <= KW_CHARS);
            for (int i = 0; same && i < kw_words[k].len(); i++)
                if (lx_head[i] != kw_words[k][i])
                    same = 1'b0;
            if (same)
                return TK_INTEIRO + 6'(k);
        end
        return TK_IDENT;
    endfunction

    function automatic bit lx_append(logic [7:0] b);
        if (lx_count >= MAX_LEN)
        begin
            lx_fail(MAX_LEN, b);
            return 1'b0;
        end
        if (lx_count < KW_CHARS)
            lx_head[lx_count] = b;
        lx_count++;
        return 1'b1;
    endfunction

    function automatic void lx_flush();
        case (lx_state)
            S_IDENT:            lx_note(lx_word_code(), lx_count, 8'h00);
            S_NUM, S_NUM_DOT:   lx_note(lx_real ? TK_NUM_REAL : TK_NUM_INT, lx_count, 8'h00);
            S_SLASH:            lx_note(TK_DIV, 1, 8'h00);
            S_LT:               lx_note(TK_LT, 1, 8'h00);
            S_GT:               lx_note(TK_GT, 1, 8'h00);
            S_EQ:               lx_note(TK_ASSIGN, 1, 8'h00);
            S_AMP:              lx_fail(1, CH_AMP);
            S_BAR:              lx_fail(1, CH_BAR);
            default:            ;
        endcase
        lx_state = S_IDLE;
    endfunction

    function automatic void lx_fresh(logic [7:0] b);
        lx_state = S_IDLE;
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF)
            return;
        if (is_letter(b) || is_num(b))
        begin
            lx_count   = 1;
            lx_head[0] = b;
            lx_real    = 1'b0;
            lx_state   = is_letter(b) ? S_IDENT : S_NUM;
            return;
        end
        case (b)
            CH_SLASH: lx_state = S_SLASH;
            CH_LT:    lx_state = S_LT;
            CH_GT:    lx_state = S_GT;
            CH_EQ:    lx_state = S_EQ;
            CH_AMP:   lx_state = S_AMP;
            CH_BAR:   lx_state = S_BAR;
            CH_PLUS:  lx_note(TK_PLUS, 1, 8'h00);
            CH_MINUS: lx_note(TK_MINUS, 1, 8'h00);
            CH_STAR:  lx_note(TK_MUL, 1, 8'h00);
            CH_SEMI:  lx_note(TK_SEMI, 1, 8'h00);
            CH_COMMA: lx_note(TK_COMMA, 1, 8'h00);
            CH_LPAR:  lx_note(TK_LPAREN, 1, 8'h00);
            CH_RPAR:  lx_note(TK_RPAREN, 1, 8'h00);
            CH_LBRC:  lx_note(TK_LBRACE, 1, 8'h00);
            CH_RBRC:  lx_note(TK_RBRACE, 1, 8'h00);
            default:  lx_fail(1, b);
        endcase
    endfunction

    function automatic void lx_pair(logic [7:0] b, logic [5:0] two_code);
        if (b == CH_EQ)
        begin
            lx_note(two_code, 2, 8'h00);
            lx_state = S_IDLE;
        end
        else
        begin
            lx_flush();
            lx_fresh(b);
        end
    endfunction

    function automatic void lex_step(logic eoi, logic [7:0] b);
        int unsigned first;
        token_word_t w;
        first = tokens_due.size();
        if (lx_halt)
            return;
        if (eoi)
        begin
            lx_flush();
            if (!lx_halt)
                lx_note(TK_EOF, 0, 8'h00);
        end
        else
        begin
            case (lx_state)
                S_IDENT:
                    if (is_letter(b) || is_num(b) || b == CH_UNDER)
                        void'(lx_append(b));
                    else
                    begin
                        lx_flush();
                        lx_fresh(b);
                    end
                S_NUM:
                    if (is_num(b))
                        void'(lx_append(b));
                    else if (b == CH_DOT)
                    begin
                        if (lx_append(b))
                        begin
                            lx_real  = 1'b1;
                            lx_state = S_NUM_DOT;
                        end
                    end
                    else
                    begin
                        lx_flush();
                        lx_fresh(b);
                    end
                S_NUM_DOT:
                    if (is_num(b))
                    begin
                        if (lx_append(b))
                            lx_state = S_NUM;
                    end
                    else
                    begin
                        lx_flush();
                        lx_fresh(b);
                    end
                S_SLASH:
                    if (b == CH_STAR)
                        lx_state = S_COMMENT;
                    else
                    begin
                        lx_flush();
                        lx_fresh(b);
                    end
                S_COMMENT:
                    if (b == CH_STAR)
                        lx_state = S_CSTAR;
                S_CSTAR:
                    if (b == CH_SLASH)
                        lx_state = S_IDLE;
                    else if (b != CH_STAR)
                        lx_state = S_COMMENT;
                S_LT: lx_pair(b, TK_LE);
                S_GT: lx_pair(b, TK_GE);
                S_EQ: lx_pair(b, TK_EQEQ);
                S_AMP:
                    if (b == CH_AMP)
                    begin
                        lx_note(TK_AND, 2, 8'h00);
                        lx_state = S_IDLE;
                    end
                    else
                        lx_fail(1, CH_AMP);
                S_BAR:
                    if (b == CH_BAR)
                    begin
                        lx_note(TK_OR, 2, 8'h00);
                        lx_state = S_IDLE;
                    end
                    else
                        lx_fail(1, CH_BAR);
                default: lx_fresh(b);
            endcase
        end
        if (tokens_due.size() > first)
        begin
            w = tokens_due.pop_back();
            w.last = 1'b1;
            tokens_due.push_back(w);
        end
    endfunction

    task automatic send_word(input logic eoi, input logic [7:0] ch, output int unsigned added);
        int unsigned before_n;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = eoi;
        s_tdata  = ch;
        do
            @(posedge clk);
        while (!s_tready);
        before_n = tokens_due.size();
        lex_step(eoi, ch);
        added = tokens_due.size() - before_n;
        words_sent++;
    endtask

    task automatic build_script();
        logic [7:0]  piece [$];
        piece_t      kind;
        piece_t      prev_kind;
        int unsigned run_len;
        int unsigned n;
        int unsigned pick;
        logic [7:0]  last_ch;
        logic [7:0]  b;
        bit          gap;
        bit          open_end;
        bit          merged;
        string       s;
        prev_kind = PIECE_OTHER;
        run_len   = 0;
        last_ch   = 8'h00;
        while (script.size() < RANDOM_ITEMS)
        begin
            piece.delete();
            kind     = PIECE_OTHER;
            open_end = 1'b0;
            pick     = $urandom_range(99);
            if (pick < 25)
            begin
                kind = PIECE_WORD;
                if ($urandom_range(1) == 0)
                begin
                    s = kw_words[$urandom_range(9)];
                    for (int i = 0; i < s.len(); i++)
                        piece.push_back(s[i]);
                    n = $urandom_range(3);
                    if (n == 2 && piece.size() > 1)
                        void'(piece.pop_back());
                    else if (n == 3)
                        piece.push_back(word_tail[$urandom_range(word_tail.len() - 1)]);
                end
                else
                begin
                    if ($urandom_range(39) == 0)
                        n = $urandom_range(1) ? MAX_LEN : $urandom_range(MAX_LEN - 1, 60);
                    else
                        n = $urandom_range(10, 1);
                    piece.push_back(letters[$urandom_range(letters.len() - 1)]);
                    repeat (n - 1)
                        piece.push_back(word_tail[$urandom_range(word_tail.len() - 1)]);
                end
            end
            else if (pick < 40)
            begin
                kind = PIECE_NUMBER;
                if ($urandom_range(59) == 0)
                    repeat (MAX_LEN)
                        piece.push_back(digits[$urandom_range(9)]);
                else
                begin
                    n = $urandom_range(3, 1);
                    for (int g = 0; g < n; g++)
                    begin
                        if (g > 0)
                            piece.push_back(CH_DOT);
                        repeat ($urandom_range(4, 1))
                            piece.push_back(digits[$urandom_range(9)]);
                    end
                    if ($urandom_range(4) == 0)
                        piece.push_back(CH_DOT);
                end
            end
            else if (pick < 65)
            begin
                s = op_text[$urandom_range(11)];
                for (int i = 0; i < s.len(); i++)
                    piece.push_back(s[i]);
            end
            else if (pick < 80)
                piece.push_back(punct_chars[$urandom_range(punct_chars.len() - 1)]);
            else if (pick < 90)
                repeat ($urandom_range(3, 1))
                    piece.push_back(blanks[$urandom_range(2)]);
            else if (pick < 96)
            begin
                piece.push_back(CH_SLASH);
                piece.push_back(CH_STAR);
                repeat ($urandom_range(10))
                begin
                    b = 8'($urandom_range(255));
                    if (piece[$] == CH_STAR && b == CH_SLASH)
                        b = "x";
                    piece.push_back(b);
                end
                if ($urandom_range(4) == 0)
                    open_end = 1'b1;
                else
                begin
                    repeat ($urandom_range(3, 1))
                        piece.push_back(CH_STAR);
                    piece.push_back(CH_SLASH);
                end
            end
            else
                kind = PIECE_END;

            gap = 1'b0;
            if ((kind == PIECE_WORD || kind == PIECE_NUMBER) &&
                (prev_kind == PIECE_WORD || prev_kind == PIECE_NUMBER))
                gap = (kind == PIECE_NUMBER && prev_kind == PIECE_WORD) ||
                      (run_len + piece.size() > MAX_LEN) || ($urandom_range(9) < 7);
            if (kind != PIECE_END && last_ch == CH_SLASH && piece[0] == CH_STAR)
                gap = 1'b1;
            if (gap)
                script.push_back('{1'b0, blanks[$urandom_range(2)]});

            if (kind == PIECE_END)
                script.push_back('{1'b1, 8'($urandom_range(255))});
            else
                foreach (piece[i])
                    script.push_back('{1'b0, piece[i]});
            if (open_end)
                script.push_back('{1'b1, 8'($urandom_range(255))});

            merged = !gap && (prev_kind == PIECE_WORD || prev_kind == PIECE_NUMBER);
            if (kind == PIECE_WORD || kind == PIECE_NUMBER)
                run_len = merged ? run_len + piece.size() : piece.size();
            else
                run_len = 0;
            prev_kind = open_end ? PIECE_OTHER : kind;
            last_ch   = (kind == PIECE_END || open_end) ? 8'h00 : piece[$];
        end
    endtask

    task automatic run_fault_tail(output fault_t f);
        logic [7:0]  b;
        logic [7:0]  opener;
        int unsigned added;
        bit          numeric;
        send_word(1'b1, 8'h00, added);
        f = fault_t'($urandom_range(4));
        case (f)
            FAULT_STRAY:
            begin
                do
                    b = 8'($urandom_range(255));
                while (can_open(b));
                send_word(1'b0, b, added);
            end
            FAULT_AMP, FAULT_BAR:
            begin
                opener = (f == FAULT_AMP) ? CH_AMP : CH_BAR;
                do
                    b = 8'($urandom_range(255));
                while (b == opener);
                send_word(1'b0, opener, added);
                send_word(1'b0, b, added);
            end
            FAULT_OPEN_END:
            begin
                send_word(1'b0, $urandom_range(1) ? CH_AMP : CH_BAR, added);
                send_word(1'b1, 8'($urandom_range(255)), added);
            end
            default:
            begin
                numeric = $urandom_range(1);
                if (numeric)
                    send_word(1'b0, digits[$urandom_range(9)], added);
                else
                    send_word(1'b0, letters[$urandom_range(letters.len() - 1)], added);
                repeat (MAX_LEN)
                    if (numeric)
                        send_word(1'b0, digits[$urandom_range(9)], added);
                    else
                        send_word(1'b0, word_tail[$urandom_range(word_tail.len() - 1)], added);
            end
        endcase
        repeat (8)
            send_word(1'($urandom_range(1)), 8'($urandom_range(255)), added);
    endtask

    function automatic void log_mismatch(string what, token_word_t want, token_word_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("Mismatch (%s) at result word %0d: expected code %0d len %0d bad 0x%02h last %0b, got code %0d len %0d bad 0x%02h last %0b",
                     what, words_checked, want.code, want.len, want.bad, want.last,
                     got.code, got.len, got.bad, got.last);
    endfunction

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin : result_check
        token_word_t got;
        token_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.code = m_tdata[5:0];
            got.len  = m_tdata[12:6];
            got.bad  = m_tdata[20:13];
            got.last = m_tlast;
            if (tokens_due.size() == 0)
                log_mismatch("no word expected", '0, got);
            else
            begin
                want = tokens_due.pop_front();
                if (got != want)
                    log_mismatch("field", want, got);
                else if (m_tdata[23:21] != 3'b000)
                    log_mismatch("padding bits set", want, got);
            end
            words_checked++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int unsigned added;
        int unsigned probes;
        token_word_t w;
        fault_t      fault;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle = 38;
        rcv_idle = 81;
        foreach (probe_rows[i])
        begin
            send_word(probe_rows[i].eoi, probe_rows[i].ch, added);
            if (probe_rows[i].typed)
            begin
                repeat (added) void'(tokens_due.pop_back());
                w.code = probe_rows[i].code;
                w.len  = probe_rows[i].len;
                w.bad  = probe_rows[i].bad;
                w.last = 1'b1;
                tokens_due.push_back(w);
            end
        end
        probes = words_sent;

        build_script();
        for (int i = 0; i < script.size(); i++)
        begin
            if (i == script.size() / 3)
            begin
                snd_idle = 81;
                rcv_idle = 38;
            end
            if (i == 2 * script.size() / 3)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            send_word(script[i].eoi, script[i].ch, added);
        end
        run_fault_tail(fault);

        @(negedge clk);
        s_tvalid = 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d source words (%0d from the directed table) and checked %0d tokens.",
                 words_sent, probes, words_checked);
        $display("The stream closed with a %s error, after which the lexer had to stay silent.",
                 fault.name());
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
